// ===== rtl/core/cal_pkg.sv =====
package cal_pkg;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_END     = 3'd1,
        OP_ADVANCE = 3'd2,
        OP_RETREAT = 3'd3,
        OP_INSERT  = 3'd4,
        OP_READ    = 3'd5,
        OP_DELETE  = 3'd6,
        OP_CLEAR   = 3'd7
    } op_t;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 5;

endpackage

// ===== rtl/core/cursor_array_list.sv =====
// Cursor moves, clear and failed commands: the result strobe comes in the cycle after the accept.
// Read waits in ST_RD_WAIT for the synchronous store read. Insert: ST_SHIFT_UP, then ST_PUT
// writes the new entry, or neither when appending at the end. Delete: ST_SHIFT_DN, or none
// for the last entry. Both shifts move one entry per cycle through the single store port pair.
// A new command is taken only in ST_IDLE; results cannot be stalled by the receiver.
// Reset clears count and cursor at once; store contents stay undefined until written.
module cursor_array_list #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cal_pkg::op_t                   op,
    input  logic [cal_pkg::DATA_W-1:0]     entry_data,
    output logic                           done,
    output logic                           ok,
    output logic [cal_pkg::DATA_W-1:0]     read_data,
    output logic                           is_empty,
    output logic                           is_full,
    output logic                           at_start,
    output logic                           at_end,
    output logic [cal_pkg::STATUS_W-1:0]   entry_count,
    output logic [cal_pkg::STATUS_W-1:0]   cursor_pos
);
    import cal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = ENTRY_WIDTH;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SHIFT_UP,
        ST_PUT,
        ST_SHIFT_DN
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   cursor_reg, cursor_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [EW-1:0]   word_reg, word_next;
    logic [EW-1:0]   rdata_reg, rdata_next;
    logic            ok_reg, ok_next;
    logic            done_reg, done_next;

    logic [EW-1:0]   mem [CAPACITY];
    logic [EW-1:0]   rd_q;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [AW-1:0]   mem_ra;
    logic [EW-1:0]   mem_wd;

    logic [CW-1:0]   ptr_ext, ptr_m2, ptr_p2, count_m1, cursor_p1;
    logic [EW+DATA_W-1:0] data_ext, rdata_ext;
    logic [CW+STATUS_W-1:0] count_ext, cursor_ext;

    assign ptr_ext   = CW'(ptr_reg);
    assign ptr_m2    = ptr_ext - CW'(2);
    assign ptr_p2    = ptr_ext + CW'(2);
    assign count_m1  = count_reg - 1'b1;
    assign cursor_p1 = cursor_reg + 1'b1;
    assign data_ext  = (EW + DATA_W)'(entry_data);

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        ptr_next    = ptr_reg;
        word_next   = word_reg;
        rdata_next  = rdata_reg;
        ok_next     = ok_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = ptr_reg;
        mem_wd      = rd_q;
        mem_ra      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    word_next  = data_ext[EW-1:0];
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    rdata_next = '0;
                    case (op)
                        OP_START:   cursor_next = '0;
                        OP_END:     cursor_next = count_reg;
                        OP_ADVANCE:
                        begin
                            if (cursor_reg < count_reg)
                                cursor_next = cursor_p1;
                        end
                        OP_RETREAT:
                        begin
                            if (cursor_reg != '0)
                                cursor_next = cursor_reg - 1'b1;
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CAP_C)
                                ok_next = 1'b0;
                            else if (cursor_reg == count_reg)
                            begin
                                // Appending at the end needs no shift.
                                mem_we     = 1'b1;
                                mem_wa     = cursor_reg[AW-1:0];
                                mem_wd     = data_ext[EW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                mem_ra     = count_m1[AW-1:0];
                                ptr_next   = count_reg[AW-1:0];
                                done_next  = 1'b0;
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        OP_READ:
                        begin
                            if (cursor_reg < count_reg)
                            begin
                                mem_ra     = cursor_reg[AW-1:0];
                                done_next  = 1'b0;
                                state_next = ST_RD_WAIT;
                            end
                            else
                                ok_next = 1'b0;
                        end
                        OP_DELETE:
                        begin
                            if (cursor_reg >= count_reg)
                                ok_next = 1'b0;
                            else if (cursor_p1 == count_reg)
                                count_next = count_m1;
                            else
                            begin
                                mem_ra     = cursor_p1[AW-1:0];
                                ptr_next   = cursor_reg[AW-1:0];
                                done_next  = 1'b0;
                                state_next = ST_SHIFT_DN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        default:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                rdata_next = rd_q;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SHIFT_UP:
            begin
                // The word read last cycle moves up by one; reads run two ahead of writes.
                mem_we = 1'b1;
                if (ptr_ext == cursor_p1)
                    state_next = ST_PUT;
                else
                begin
                    mem_ra   = ptr_m2[AW-1:0];
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            ST_PUT:
            begin
                mem_we     = 1'b1;
                mem_wa     = cursor_reg[AW-1:0];
                mem_wd     = word_reg;
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SHIFT_DN:
            begin
                mem_we = 1'b1;
                if (ptr_p2 == count_reg)
                begin
                    count_next = count_m1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_ra   = ptr_p2[AW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        word_reg  <= word_next;
        rdata_reg <= rdata_next;
        ok_reg    <= ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_q <= mem[mem_ra];
    end

    assign rdata_ext  = (EW + DATA_W)'(rdata_reg);
    assign count_ext  = (CW + STATUS_W)'(count_reg);
    assign cursor_ext = (CW + STATUS_W)'(cursor_reg);

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign read_data   = rdata_ext[DATA_W-1:0];
    assign is_empty    = (count_reg == '0);
    assign is_full     = (count_reg == CAP_C);
    assign at_start    = (cursor_reg == '0);
    assign at_end      = (cursor_reg == count_reg);
    assign entry_count = count_ext[STATUS_W-1:0];
    assign cursor_pos  = cursor_ext[STATUS_W-1:0];

endmodule
